// ----- rtl/core/edf_pkg.sv -----
// Shared constants, codes and control types of the deadline task table.
package edf_pkg;

    localparam int ACTIVE_DEPTH_DEF  = 16;
    localparam int HISTORY_DEPTH_DEF = 5;

    localparam int ID_W   = 32;
    localparam int TICK_W = 32;
    localparam int PRI_W  = 5;
    localparam int WORD_W = ID_W + 2 * TICK_W;

    localparam logic [PRI_W-1:0] BASE_PRI_RESET = 5'd1;

    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic wr_word;
        logic wr_pri;
    } t_mem_ctl;

    function automatic logic [PRI_W-1:0] sat_dec(input logic [PRI_W-1:0] p);
        sat_dec = (p == '0) ? '0 : p - 1'b1;
    endfunction

endpackage

// ----- rtl/core/edf_deadline_task_table.sv -----
// Top level: sequencer of the earliest-deadline-first task table.
//
// channel  | ports                                              | handshake
// ---------+----------------------------------------------------+-------------------
// request  | i_func i_task_id i_deadline i_time_now i_query_index | start & !busy
// result   | o_status o_priority_res o_entry_id o_entry_deadline  | o_done, one cycle
//          | o_entry_time o_moved_overdue o_active_count         |
// config   | i_cfg_data (baseline_priority)                     | i_cfg_valid & o_cfg_ready
//
// A request first retires overdue heads, each with a read and a check. A create
// then scans with a read and a check per entry passed and shifts with a read and
// a write per entry moved; a delete searches the same way, closes the gap with a
// read and a write per entry and fixes the priority of each entry ahead of the
// gap; a query reads one entry. All of it goes through the one port pair of the
// table memory. The strobe o_done rises in the cycle after the last step and busy
// falls with it. Reset is synchronous; table contents need no clearing.
module edf_deadline_task_table #(
    parameter int ACTIVE_DEPTH  = edf_pkg::ACTIVE_DEPTH_DEF,
    parameter int HISTORY_DEPTH = edf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_task_id,
    input  logic [31:0] i_deadline,
    input  logic [31:0] i_time_now,
    input  logic [3:0]  i_query_index,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [4:0]  o_priority_res,
    output logic [31:0] o_entry_id,
    output logic [31:0] o_entry_deadline,
    output logic [31:0] o_entry_time,
    output logic [4:0]  o_moved_overdue,
    output logic [4:0]  o_active_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    localparam int AW = $clog2(ACTIVE_DEPTH);
    localparam int CW = $clog2(ACTIVE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int QW = (CW > 4) ? CW : 4;
    localparam int PW = edf_pkg::PRI_W;
    localparam int WW = edf_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_OD_RD, S_OD_CHK, S_OP, S_SC_RD, S_SC_CHK, S_SH_RD, S_SH_WR,
        S_FD_RD, S_FD_CHK, S_RM_RD, S_RM_WR, S_PD, S_Q_RD, S_Q_CHK
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_len, r_k, r_pos, r_moved;
    logic [AW-1:0]   r_head;
    logic [PW-1:0]   r_base, r_p, r_hpri;
    logic [1:0]      r_func;
    logic [31:0]     r_id, r_dl, r_now, r_edl;
    logic [3:0]      r_qidx;

    logic            r_valid;
    logic [1:0]      r_status;
    logic [4:0]      r_prio_o, r_moved_o, r_count_o;
    logic [31:0]     r_id_o, r_dl_o, r_time_o;

    logic [CW-1:0]   rd_log;
    logic [AW-1:0]   raddr, waddr;
    edf_pkg::t_mem_ctl mem_ctl;
    logic [WW-1:0]   wword, rword;
    logic [PW-1:0]   wpri, rpri, p_dec;
    logic [31:0]     rd_id, rd_dl, rd_rel;
    logic            od_push, done_push;

    function automatic logic [AW-1:0] phys(input logic [CW-1:0] k, input logic [AW-1:0] h);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(k);
        if (s >= SW'(ACTIVE_DEPTH)) begin
            s = s - SW'(ACTIVE_DEPTH);
        end
        phys = s[AW-1:0];
    endfunction

    assign rd_id  = rword[WW-1 -: 32];
    assign rd_dl  = rword[63:32];
    assign rd_rel = rword[31:0];
    assign p_dec  = edf_pkg::sat_dec(r_p);

    always_comb begin
        rd_log = r_k;
        if (r_state == S_SH_RD && r_k != '0) begin
            rd_log = r_k - 1'b1;
        end else if (r_state == S_RM_RD) begin
            rd_log = r_k + 1'b1;
        end
    end

    assign raddr = phys(rd_log, r_head);
    assign waddr = phys(r_k, r_head);

    always_comb begin
        mem_ctl = '0;
        wword   = rword;
        wpri    = rpri;
        unique case (r_state)
            S_SH_RD: begin
                if (r_k == r_pos) begin
                    mem_ctl = '{wr_word: 1'b1, wr_pri: 1'b1};
                    wword   = {r_id, r_dl, r_now};
                    wpri    = r_p;
                end
            end
            S_SH_WR, S_RM_WR: mem_ctl = '{wr_word: 1'b1, wr_pri: 1'b1};
            S_PD: begin
                if (r_k != r_pos) begin
                    mem_ctl.wr_pri = 1'b1;
                    wpri           = p_dec;
                end
            end
            default: ;
        endcase
    end

    assign od_push   = (r_state == S_OD_CHK) && (r_now >= rd_dl);
    assign done_push = (r_state == S_FD_CHK) && (rd_id == r_id);

    edf_mem #(.DEPTH(ACTIVE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_raddr (raddr),
        .i_waddr (waddr),
        .i_ctl   (mem_ctl),
        .i_wword (wword),
        .i_wpri  (wpri),
        .o_rword (rword),
        .o_rpri  (rpri)
    );

    edf_hist #(.DEPTH(HISTORY_DEPTH)) u_od_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (od_push),
        .i_id    (rd_id),
        .i_time  (32'd0)
    );

    edf_hist #(.DEPTH(HISTORY_DEPTH)) u_done_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (done_push),
        .i_id    (r_id),
        .i_time  (r_now - 32'd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_head  <= '0;
            r_base  <= edf_pkg::BASE_PRI_RESET;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func  <= i_func;
                        r_id    <= i_task_id;
                        r_dl    <= i_deadline;
                        r_now   <= i_time_now;
                        r_qidx  <= i_query_index;
                        r_moved <= '0;
                        // point the first head read at position zero
                        r_k     <= '0;
                        r_state <= S_OD_RD;
                    end
                end
                S_OD_RD: begin
                    r_k     <= '0;
                    r_state <= (r_len == '0) ? S_OP : S_OD_CHK;
                end
                S_OD_CHK: begin
                    if (od_push) begin
                        // retire the head
                        r_head  <= (r_head == AW'(ACTIVE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        r_len   <= r_len - 1'b1;
                        r_moved <= r_moved + 1'b1;
                        r_state <= S_OD_RD;
                    end else begin
                        r_hpri  <= rpri;
                        r_state <= S_OP;
                    end
                end
                S_OP: begin
                    r_k <= '0;
                    r_status  <= edf_pkg::ST_OK;
                    r_prio_o  <= '0;
                    r_id_o    <= '0;
                    r_dl_o    <= '0;
                    r_time_o  <= '0;
                    r_moved_o <= 5'(r_moved);
                    r_count_o <= 5'(r_len);
                    case (r_func)
                        edf_pkg::FUNC_CREATE: begin
                            if (r_len == CW'(ACTIVE_DEPTH)) begin
                                r_status <= edf_pkg::ST_FULL;
                                r_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_p     <= (r_len != '0) ? r_hpri : r_base;
                                r_state <= S_SC_RD;
                            end
                        end
                        edf_pkg::FUNC_DELETE: r_state <= S_FD_RD;
                        edf_pkg::FUNC_QUERY: begin
                            if (QW'(r_qidx) >= QW'(r_len)) begin
                                r_status <= edf_pkg::ST_EMPTY;
                                r_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_k     <= CW'(r_qidx);
                                r_state <= S_Q_RD;
                            end
                        end
                        default: begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_SC_RD: begin
                    if (r_k == r_len) begin
                        r_pos   <= r_k;
                        r_state <= S_SH_RD;
                    end else begin
                        r_state <= S_SC_CHK;
                    end
                end
                S_SC_CHK: begin
                    if (r_dl >= rd_dl) begin
                        r_p     <= p_dec;
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SC_RD;
                    end else begin
                        r_pos   <= r_k;
                        r_k     <= r_len;
                        r_state <= S_SH_RD;
                    end
                end
                S_SH_RD: begin
                    if (r_k == r_pos) begin
                        r_len     <= r_len + 1'b1;
                        r_count_o <= 5'(r_len + 1'b1);
                        r_prio_o  <= r_p;
                        r_id_o    <= r_id;
                        r_dl_o    <= r_dl;
                        r_time_o  <= r_now;
                        r_valid   <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    r_k     <= r_k - 1'b1;
                    r_state <= S_SH_RD;
                end
                S_FD_RD: begin
                    if (r_k == r_len) begin
                        r_status <= edf_pkg::ST_NOT_FOUND;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_FD_CHK;
                    end
                end
                S_FD_CHK: begin
                    if (done_push) begin
                        r_pos   <= r_k;
                        r_edl   <= rd_dl;
                        r_state <= S_RM_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_FD_RD;
                    end
                end
                S_RM_RD: begin
                    if (r_k + 1'b1 == r_len) begin
                        r_len     <= r_len - 1'b1;
                        r_count_o <= 5'(r_len - 1'b1);
                        r_p       <= r_hpri;
                        r_k       <= '0;
                        r_state   <= S_PD;
                    end else begin
                        r_state <= S_RM_WR;
                    end
                end
                S_RM_WR: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= S_RM_RD;
                end
                S_PD: begin
                    if (r_k == r_pos) begin
                        r_id_o   <= r_id;
                        r_dl_o   <= r_edl;
                        r_time_o <= r_now - 32'd1;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_p     <= p_dec;
                        r_k     <= r_k + 1'b1;
                    end
                end
                S_Q_RD: r_state <= S_Q_CHK;
                S_Q_CHK: begin
                    r_prio_o <= rpri;
                    r_id_o   <= rd_id;
                    r_dl_o   <= rd_dl;
                    r_time_o <= rd_rel;
                    r_valid  <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_done           = r_valid;
    assign o_status         = r_status;
    assign o_priority_res   = r_prio_o;
    assign o_entry_id       = r_id_o;
    assign o_entry_deadline = r_dl_o;
    assign o_entry_time     = r_time_o;
    assign o_moved_overdue  = r_moved_o;
    assign o_active_count   = r_count_o;

endmodule

// ----- rtl/core/edf_mem.sv -----
// Active table storage: entry word memory and priority memory, registered read.
module edf_mem #(
    parameter int DEPTH = edf_pkg::ACTIVE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic [AW-1:0]             i_raddr,
    input  logic [AW-1:0]             i_waddr,
    input  edf_pkg::t_mem_ctl         i_ctl,
    input  logic [edf_pkg::WORD_W-1:0] i_wword,
    input  logic [edf_pkg::PRI_W-1:0] i_wpri,
    output logic [edf_pkg::WORD_W-1:0] o_rword,
    output logic [edf_pkg::PRI_W-1:0] o_rpri
);

    logic [edf_pkg::WORD_W-1:0] r_word_mem [DEPTH];
    logic [edf_pkg::PRI_W-1:0]  r_pri_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_word) begin
            r_word_mem[i_waddr] <= i_wword;
        end
        if (i_ctl.wr_pri) begin
            r_pri_mem[i_waddr] <= i_wpri;
        end
        o_rword <= r_word_mem[i_raddr];
        o_rpri  <= r_pri_mem[i_raddr];
    end

endmodule

// ----- rtl/core/edf_hist.sv -----
// History line of retired ids and times; drops the oldest entry when full.
module edf_hist #(
    parameter int DEPTH = edf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [edf_pkg::ID_W-1:0]   i_id,
    input  logic [edf_pkg::TICK_W-1:0] i_time
);

    localparam int LW = $clog2(DEPTH + 1);

    logic [edf_pkg::ID_W-1:0]   r_ids   [DEPTH];
    logic [edf_pkg::TICK_W-1:0] r_times [DEPTH];
    logic [LW-1:0]              r_len;
    logic                       full;

    assign full = (r_len == LW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_push && !full) begin
            r_len <= r_len + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int j = 0; j < DEPTH; j++) begin
                if (full) begin
                    // drop the oldest, append at the end
                    if (j == DEPTH - 1) begin
                        r_ids[j]   <= i_id;
                        r_times[j] <= i_time;
                    end else begin
                        r_ids[j]   <= r_ids[j+1];
                        r_times[j] <= r_times[j+1];
                    end
                end else if (LW'(j) == r_len) begin
                    r_ids[j]   <= i_id;
                    r_times[j] <= i_time;
                end
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the earliest-deadline-first task table.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  prio;
        logic [31:0] id;
        logic [31:0] dl;
        logic [31:0] tm;
        logic [4:0]  moved;
        logic [4:0]  count;
    } t_result;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] id;
        logic [31:0] dl;
        logic [31:0] now;
        logic [3:0]  qidx;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = '0;
    logic [31:0] i_task_id = '0;
    logic [31:0] i_deadline = '0;
    logic [31:0] i_time_now = '0;
    logic [3:0]  i_query_index = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [4:0]  o_priority_res;
    logic [31:0] o_entry_id;
    logic [31:0] o_entry_deadline;
    logic [31:0] o_entry_time;
    logic [4:0]  o_moved_overdue;
    logic [4:0]  o_active_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;

    edf_deadline_task_table dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] tbl_id [16];
    logic [31:0] tbl_dl [16];
    logic [31:0] tbl_rel[16];
    logic [4:0]  tbl_pri[16];
    int          tbl_len;
    logic [4:0]  base_pri;

    t_result     pending[$];
    int          errors;
    int          n_mismatch;
    bit          quiet_tail;

    function automatic t_result schedule(logic [1:0] f, logic [31:0] id, logic [31:0] dl,
                                         logic [31:0] now, logic [3:0] q);
        t_result     r;
        logic [4:0]  p;
        int          pos;
        r = '0;
        while (tbl_len > 0 && now >= tbl_dl[0]) begin
            for (int k = 0; k + 1 < tbl_len; k++) begin
                tbl_id[k] = tbl_id[k+1]; tbl_dl[k] = tbl_dl[k+1];
                tbl_rel[k] = tbl_rel[k+1]; tbl_pri[k] = tbl_pri[k+1];
            end
            tbl_len--;
            r.moved++;
        end
        case (f)
            edf_pkg::FUNC_CREATE: begin
                if (tbl_len >= 16) begin
                    r.status = edf_pkg::ST_FULL;
                end else begin
                    p = tbl_len > 0 ? tbl_pri[0] : base_pri;
                    pos = 0;
                    while (pos < tbl_len && dl >= tbl_dl[pos]) begin
                        p = (p == 0) ? 5'd0 : p - 5'd1;
                        pos++;
                    end
                    for (int k = tbl_len; k > pos; k--) begin
                        tbl_id[k] = tbl_id[k-1]; tbl_dl[k] = tbl_dl[k-1];
                        tbl_rel[k] = tbl_rel[k-1]; tbl_pri[k] = tbl_pri[k-1];
                    end
                    tbl_id[pos] = id; tbl_dl[pos] = dl; tbl_rel[pos] = now;
                    tbl_pri[pos] = p;
                    tbl_len++;
                    r.prio = p; r.id = id; r.dl = dl; r.tm = now;
                end
            end
            edf_pkg::FUNC_DELETE: begin
                pos = 0;
                while (pos < tbl_len && tbl_id[pos] != id) pos++;
                if (pos >= tbl_len) begin
                    r.status = edf_pkg::ST_NOT_FOUND;
                end else begin
                    p = tbl_pri[0];
                    r.id = id; r.dl = tbl_dl[pos]; r.tm = now - 32'd1;
                    for (int k = pos; k + 1 < tbl_len; k++) begin
                        tbl_id[k] = tbl_id[k+1]; tbl_dl[k] = tbl_dl[k+1];
                        tbl_rel[k] = tbl_rel[k+1]; tbl_pri[k] = tbl_pri[k+1];
                    end
                    tbl_len--;
                    for (int k = 0; k < pos; k++) begin
                        p = (p == 0) ? 5'd0 : p - 5'd1;
                        tbl_pri[k] = p;
                    end
                end
            end
            edf_pkg::FUNC_QUERY: begin
                if (q >= tbl_len) begin
                    r.status = edf_pkg::ST_EMPTY;
                end else begin
                    r.prio = tbl_pri[q]; r.id = tbl_id[q];
                    r.dl = tbl_dl[q]; r.tm = tbl_rel[q];
                end
            end
            default: ;
        endcase
        r.count = tbl_len[4:0];
        return r;
    endfunction

    // check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && o_done) begin
            got = {o_status, o_priority_res, o_entry_id, o_entry_deadline, o_entry_time,
                   o_moved_overdue, o_active_count};
            if (pending.size() == 0) begin
                errors++;
                if (n_mismatch++ < 10) $display("unexpected result %h", got);
            end else begin
                exp_r = pending.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    if (n_mismatch++ < 10)
                        $display("mismatch: exp st=%0d pri=%0d id=%h dl=%h t=%h mv=%0d cnt=%0d",
                                 exp_r.status, exp_r.prio, exp_r.id, exp_r.dl, exp_r.tm,
                                 exp_r.moved, exp_r.count,
                                 "\n          got st=%0d pri=%0d id=%h dl=%h t=%h mv=%0d cnt=%0d",
                                 got.status, got.prio, got.id, got.dl, got.tm,
                                 got.moved, got.count);
                end
            end
        end
    end

    // drop start for a random burst; otherwise keep it up for the next transaction
    task automatic gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    // send one request; typed expectations are checked against the predictor too
    task automatic issue(logic [1:0] f, logic [31:0] id, logic [31:0] dl, logic [31:0] now,
                         logic [3:0] q, bit typed = 0, t_result want = '0);
        t_result r;
        gap();
        start <= 1'b1;
        i_func <= f; i_task_id <= id; i_deadline <= dl; i_time_now <= now;
        i_query_index <= q;
        do @(posedge i_clk); while (busy);
        r = schedule(f, id, dl, now, q);
        if (typed && r !== want) begin
            errors++;
            $display("directed row disagrees with prediction: %h vs %h", want, r);
        end
        pending.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_base(logic [4:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        base_pri = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    t_row        rows[$];
    logic [31:0] clk_now;
    logic [31:0] id_pool[8];

    initial begin
        errors = 0; n_mismatch = 0; quiet_tail = 0;
        tbl_len = 0; base_pri = edf_pkg::BASE_PRI_RESET;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table cases, extremes, unused func
        rows = '{
            '{edf_pkg::FUNC_QUERY,  32'h0, 32'h0, 32'h0, 4'd0, 1,
              {edf_pkg::ST_EMPTY, 5'd0, 96'h0, 5'd0, 5'd0}},
            '{edf_pkg::FUNC_DELETE, 32'hFFFFFFFF, 32'h0, 32'h0, 4'd15, 1,
              {edf_pkg::ST_NOT_FOUND, 5'd0, 96'h0, 5'd0, 5'd0}},
            '{edf_pkg::FUNC_CREATE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 4'd0, 1,
              {edf_pkg::ST_OK, 5'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 5'd0, 5'd1}},
            '{edf_pkg::FUNC_CREATE, 32'h0, 32'h10, 32'h1, 4'd0, 0, '0},
            '{edf_pkg::FUNC_CREATE, 32'h0, 32'h10, 32'h2, 4'd0, 0, '0},
            '{2'd3, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'h3, 4'd9, 0, '0},
            '{edf_pkg::FUNC_QUERY,  32'h0, 32'h0, 32'h4, 4'd1, 0, '0},
            '{edf_pkg::FUNC_QUERY,  32'h0, 32'h0, 32'h4, 4'd15, 0, '0},
            '{edf_pkg::FUNC_DELETE, 32'h0, 32'h0, 32'h0, 4'd0, 0, '0},
            '{edf_pkg::FUNC_DELETE, 32'hFFFFFFFF, 32'h0, 32'h0, 4'd0, 0, '0},
            '{edf_pkg::FUNC_CREATE, 32'h55555555, 32'h20, 32'h5, 4'd0, 0, '0},
            '{edf_pkg::FUNC_QUERY,  32'h0, 32'h0, 32'hFFFFFFFF, 4'd0, 0, '0}
        };
        foreach (rows[i])
            issue(rows[i].func, rows[i].id, rows[i].dl, rows[i].now, rows[i].qidx,
                  rows[i].typed, rows[i].want);
        // fill the table, then overflow it, then expire everything at once
        for (int i = 0; i < 17; i++)
            issue(edf_pkg::FUNC_CREATE, i, 32'h100 + (i % 5), 32'h10, 4'(i));
        issue(edf_pkg::FUNC_QUERY, 32'd0, 32'd0, 32'h10, 4'd15);
        issue(edf_pkg::FUNC_DELETE, 32'd3, 32'd0, 32'h0, 4'd0);
        issue(edf_pkg::FUNC_QUERY, 32'd0, 32'd0, 32'hFFFFFFFF, 4'd0);

        clk_now = 32'h0;
        for (int s = 0; s < 4; s++) begin
            case (s)
                0: write_base(5'd31);
                1: write_base(5'd0);
                2: write_base(5'(($urandom_range(1, 30))));
                default: write_base(5'd7);
            endcase
            if (s == 3) quiet_tail = 1;
            foreach (id_pool[i]) id_pool[i] = $urandom();
            for (int n = 0; n < 470; n++) begin
                logic [1:0]  f;
                logic [31:0] id, dl, now;
                int          pick;
                pick = $urandom_range(0, 99);
                f = pick < 50 ? edf_pkg::FUNC_CREATE : pick < 75 ? edf_pkg::FUNC_DELETE :
                    pick < 97 ? edf_pkg::FUNC_QUERY : 2'd3;
                id = $urandom_range(0, 9) == 0 ? $urandom() : id_pool[$urandom_range(0, 7)];
                // mostly advance time slowly so the table fills; sometimes jump
                if ($urandom_range(0, 29) == 0) clk_now = $urandom();
                else clk_now = clk_now + $urandom_range(0, 3);
                now = clk_now;
                dl = $urandom_range(0, 19) == 0 ? $urandom() : now + $urandom_range(0, 200);
                issue(f, id, dl, now, 4'($urandom_range(0, 15)));
            end
        end
        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
